@@ rtl/bmp_pkg.sv @@
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the bone matrix palette.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int MaxBones  = 256;
  localparam int FracBits  = 16;
  localparam int DataW     = 32;
  localparam int ProdW     = 2 * DataW;
  localparam int AccW      = ProdW + 2;
  localparam int NumLanes  = 4;
  localparam int BankDepth = MaxBones * 4;
  localparam int BankAw    = $clog2(BankDepth);
  localparam int CntW      = 3;

  // Phases of one four-term pass, counted from the first read.
  localparam logic [CntW-1:0] CntMulFirst = 3'd1;
  localparam logic [CntW-1:0] CntMulLast  = 3'd4;
  localparam logic [CntW-1:0] CntAccFirst = 3'd2;
  localparam logic [CntW-1:0] CntAccLast  = 3'd5;
  localparam logic [CntW-1:0] CntDone     = 3'd6;

  localparam logic [1:0] RowLast = 2'd3;

  typedef struct packed {
    logic [7:0]              bone_index;
    logic [7:0]              parent_index;
    logic [1:0]              row_index;
    logic signed [DataW-1:0] local_c0;
    logic signed [DataW-1:0] local_c1;
    logic signed [DataW-1:0] local_c2;
    logic signed [DataW-1:0] local_c3;
    logic signed [DataW-1:0] offset_c0;
    logic signed [DataW-1:0] offset_c1;
    logic signed [DataW-1:0] offset_c2;
    logic signed [DataW-1:0] offset_c3;
    logic                    last_bone;
  } in_item_t;

  typedef struct packed {
    logic [7:0]              out_bone;
    logic [1:0]              out_row;
    logic signed [DataW-1:0] final_e0;
    logic signed [DataW-1:0] final_e1;
    logic signed [DataW-1:0] final_e2;
    logic signed [DataW-1:0] final_e3;
    logic                    row_last;
    logic                    range_done;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic first;
  } lane_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_WRITE,
    ST_FINAL
  } state_e;

endpackage

@@ rtl/bmp_ram.sv @@
// ----------------------------------------------------------------------------
// bmp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmp_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/bmp_lane.sv @@
// ----------------------------------------------------------------------------
// bmp_lane
// One multiply-accumulate lane: exact four-term dot product, then rounding
// half up and saturation to the fixed-point range.
// ----------------------------------------------------------------------------
module bmp_lane (
  input  logic                              clk_i,
  input  bmp_pkg::lane_ctrl_t               ctrl_i,
  input  logic signed [bmp_pkg::DataW-1:0]  a_i,
  input  logic signed [bmp_pkg::DataW-1:0]  b_i,
  output logic signed [bmp_pkg::DataW-1:0]  res_o
);
  import bmp_pkg::*;

  localparam logic signed [AccW-1:0] SatMax =
    {{(AccW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin =
    {{(AccW-DataW+1){1'b1}}, {(DataW-1){1'b0}}};
  localparam logic signed [AccW-1:0] Half = AccW'(1) << (FracBits - 1);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-1:0]  shifted;

  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      // Both operands are signed, so the product is exact at 2*DataW bits.
      prod_q <= a_i * b_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= ctrl_i.first ? prod_ext : acc_q + prod_ext;
    end
  end

  always_comb begin
    rnd     = acc_q + Half;
    shifted = rnd >>> FracBits;
    if (shifted > SatMax) begin
      res_o = SatMax[DataW-1:0];
    end else if (shifted < SatMin) begin
      res_o = SatMin[DataW-1:0];
    end else begin
      res_o = shifted[DataW-1:0];
    end
  end

endmodule

@@ rtl/bone_matrix_palette.sv @@
// ----------------------------------------------------------------------------
// bone_matrix_palette
// Skinning matrix palette: chains bone root matrices and emits the
// transposed product of offset and root matrix after each fourth row.
// ----------------------------------------------------------------------------
// One transaction carries one row of a bone. Four multiply-accumulate lanes
// each work through a four-term dot product in each pass, fed one word per
// cycle from the root store (one bank per matrix column): a root pass
// gives each lane its own bank, a final pass shares bank k across lanes.
// A child bone's row takes a root pass, a store write and the idle state,
// a row of bone 0 only the store write and the idle state; a fourth row
// adds four final passes, one per result row, which wait on output stalls.
// The root store is not cleared: read only rows that were written.
module bone_matrix_palette (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bmp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bmp_pkg::out_item_t out_data_o
);
  import bmp_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      k_q, k_d;
  in_item_t        item_q;
  logic            parent_ok_q;
  logic signed [DataW-1:0] hold_q [NumLanes][4];
  logic            out_valid_q;
  out_item_t       out_q;

  logic accept, load_out, bank_we;
  logic [BankAw-1:0] rd_addr, wr_addr;
  logic [7:0]        sel_bone;
  logic [1:0]        m_op;
  logic [CntW-1:0]   cnt_m1;
  logic signed [DataW-1:0] local_row [4];
  logic signed [DataW-1:0] rd_data [NumLanes];
  logic signed [DataW-1:0] wr_data [NumLanes];
  logic signed [DataW-1:0] lane_a [NumLanes];
  logic signed [DataW-1:0] lane_b [NumLanes];
  logic signed [DataW-1:0] lane_res [NumLanes];
  lane_ctrl_t lane_ctrl;
  logic busy_pass;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign local_row[0] = item_q.local_c0;
  assign local_row[1] = item_q.local_c1;
  assign local_row[2] = item_q.local_c2;
  assign local_row[3] = item_q.local_c3;

  assign busy_pass = (state_q == ST_ROOT) || (state_q == ST_FINAL);
  assign cnt_m1    = cnt_q - CntMulFirst;
  assign m_op      = cnt_m1[1:0];

  assign lane_ctrl.mul_en = busy_pass && cnt_q >= CntMulFirst && cnt_q <= CntMulLast;
  assign lane_ctrl.acc_en = busy_pass && cnt_q >= CntAccFirst && cnt_q <= CntAccLast;
  assign lane_ctrl.first  = cnt_q == CntAccFirst;

  // The root pass reads the parent's column per lane; a final pass reads
  // column k of the bone itself and shares it across the lanes.
  assign sel_bone = (state_q == ST_ROOT) ? item_q.parent_index : item_q.bone_index;
  assign rd_addr  = BankAw'({sel_bone, cnt_q[1:0]});
  assign wr_addr  = BankAw'({item_q.bone_index, item_q.row_index});
  assign bank_we  = (state_q == ST_WRITE) && (int'(item_q.bone_index) < MaxBones);

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    always_comb begin
      if (state_q == ST_ROOT) begin
        lane_a[g] = local_row[m_op];
        lane_b[g] = parent_ok_q ? rd_data[g] : '0;
      end else begin
        lane_a[g] = hold_q[g][m_op];
        lane_b[g] = rd_data[k_q];
      end
      wr_data[g] = (item_q.bone_index == 8'd0) ? local_row[g] : lane_res[g];
    end

    bmp_ram #(
      .Width(DataW),
      .Depth(BankDepth)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bank_we),
      .waddr_i(wr_addr),
      .wdata_i(wr_data[g]),
      .raddr_i(rd_addr),
      .rdata_o(rd_data[g])
    );

    bmp_lane u_lane (
      .clk_i (clk_i),
      .ctrl_i(lane_ctrl),
      .a_i   (lane_a[g]),
      .b_i   (lane_b[g]),
      .res_o (lane_res[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = (in_data_i.bone_index == 8'd0) ? ST_WRITE : ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (cnt_q == CntDone) begin
          state_d = ST_WRITE;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_WRITE: begin
        cnt_d = '0;
        k_d   = '0;
        state_d = (item_q.row_index == RowLast) ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        if (cnt_q == CntDone) begin
          if (!out_valid_q || !out_stall_i) begin
            load_out = 1'b1;
            cnt_d    = '0;
            k_d      = k_q + 2'd1;
            if (k_q == RowLast) begin
              state_d = ST_IDLE;
            end
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q      <= in_data_i;
      parent_ok_q <= int'(in_data_i.parent_index) < MaxBones;
      hold_q[in_data_i.row_index][0] <= in_data_i.offset_c0;
      hold_q[in_data_i.row_index][1] <= in_data_i.offset_c1;
      hold_q[in_data_i.row_index][2] <= in_data_i.offset_c2;
      hold_q[in_data_i.row_index][3] <= in_data_i.offset_c3;
    end
    // Merge the four lane results into one output row.
    if (load_out) begin
      out_q.out_bone   <= item_q.bone_index;
      out_q.out_row    <= k_q;
      out_q.final_e0   <= lane_res[0];
      out_q.final_e1   <= lane_res[1];
      out_q.final_e2   <= lane_res[2];
      out_q.final_e3   <= lane_res[3];
      out_q.row_last   <= (k_q == RowLast);
      out_q.range_done <= (k_q == RowLast) && item_q.last_bone;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/bmp_checker.sv @@
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level assertions for the bone matrix palette, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input bmp_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bmp_pkg::out_item_t out_data_o
);
  import bmp_pkg::*;

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // Every accepted row keeps the block busy in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transaction");

  // A new row is only taken once all earlier result rows but the last are gone.
  a_accept_after_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && out_valid_o |-> out_data_o.row_last)
    else $error("row accepted while result rows pending");

  // Rows other than the fourth create no result.
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.row_index != RowLast && !out_valid_o
    |=> !out_valid_o)
    else $error("result after a non-final row");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.range_done |-> out_data_o.row_last &&
    out_data_o.out_row == RowLast)
    else $error("range done off the fourth row");

endmodule

bind bone_matrix_palette bmp_checker u_bmp_checker (.*);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Bone matrix palette testbench
// Streams bone rows into the block and predicts each bone's root rows and
// transposed skinning rows in fixed point. Every output transaction is
// compared with the oldest predicted row, under varied input and output
// idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bmp_pkg::*;

  typedef logic signed [DataW-1:0] word_t;

  class palette_scoreboard;
    word_t     root_mat[MaxBones][4][4];
    word_t     offset_rows[4][4];
    bit        root_ok[MaxBones][4];
    bit        offset_ok[4];
    out_item_t pending_rows[$];
    int        errors;

    function new();
      errors = 0;
      foreach (root_ok[b, r]) root_ok[b][r] = 0;
      foreach (offset_ok[r]) offset_ok[r] = 0;
    endfunction

    // Four exact products summed, rounded half up, then saturated.
    function word_t dot4(input word_t a[4], input word_t b[4]);
      logic signed [65:0] sum;
      logic signed [65:0] r;
      longint p;
      sum = 0;
      for (int m = 0; m < 4; m++) begin
        p = longint'(a[m]) * longint'(b[m]);
        sum = sum + p;
      end
      r = (sum + (66'sd1 <<< (FracBits - 1))) >>> FracBits;
      if (r > 66'sd2147483647) return 32'h7fffffff;
      if (r < -66'sd2147483648) return 32'h80000000;
      return r[31:0];
    endfunction

    function bit bone_complete(input int b);
      return root_ok[b][0] && root_ok[b][1] && root_ok[b][2] && root_ok[b][3];
    endfunction

    // True when the item reads only store entries and held offset rows that were written.
    function bit legal(input in_item_t it);
      if (it.bone_index != 0 && !bone_complete(it.parent_index)) return 0;
      if (it.row_index == RowLast) begin
        for (int r = 0; r < 3; r++)
          if (!root_ok[it.bone_index][r] || !offset_ok[r]) return 0;
      end
      return 1;
    endfunction

    function void note(input in_item_t it);
      word_t     loc[4];
      word_t     col[4];
      word_t     rr[4];
      out_item_t o;
      loc = '{it.local_c0, it.local_c1, it.local_c2, it.local_c3};
      offset_rows[it.row_index] = '{it.offset_c0, it.offset_c1, it.offset_c2,
                                    it.offset_c3};
      offset_ok[it.row_index] = 1;
      if (it.bone_index == 0) begin
        rr = loc;
      end else begin
        for (int k = 0; k < 4; k++) begin
          for (int m = 0; m < 4; m++) col[m] = root_mat[it.parent_index][m][k];
          rr[k] = dot4(loc, col);
        end
      end
      root_mat[it.bone_index][it.row_index] = rr;
      root_ok[it.bone_index][it.row_index] = 1;
      if (it.row_index != RowLast) return;
      for (int k = 0; k < 4; k++) begin
        for (int m = 0; m < 4; m++) col[m] = root_mat[it.bone_index][m][k];
        o.out_bone   = it.bone_index;
        o.out_row    = k[1:0];
        o.final_e0   = dot4(offset_rows[0], col);
        o.final_e1   = dot4(offset_rows[1], col);
        o.final_e2   = dot4(offset_rows[2], col);
        o.final_e3   = dot4(offset_rows[3], col);
        o.row_last   = (k == 3);
        o.range_done = (k == 3) && it.last_bone;
        pending_rows = {pending_rows, o};
      end
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check(input out_item_t got);
      out_item_t e;
      if (pending_rows.size() == 0) begin
        report($sformatf("unexpected row bone %0d row %0d", got.out_bone, got.out_row));
        return;
      end
      e = pending_rows.pop_front();
      if (got !== e)
        report($sformatf({"bone %0d/%0d row %0d/%0d e %h %h %h %h / %h %h %h %h",
                          " last %b/%b done %b/%b"},
                         got.out_bone, e.out_bone, got.out_row, e.out_row,
                         got.final_e0, got.final_e1, got.final_e2, got.final_e3,
                         e.final_e0, e.final_e1, e.final_e2, e.final_e3,
                         got.row_last, e.row_last, got.range_done, e.range_done));
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  palette_scoreboard sb;
  int idle_mode;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly

  bone_matrix_palette dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 0;
  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (idle_mode == 2) out_stall_i <= ($urandom_range(0, 99) < 81);
    else if (idle_mode == 3) out_stall_i <= ($urandom_range(0, 99) < 7);
    else out_stall_i <= 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);
  end

  function word_t rand_word(input int mode);
    case (mode)
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'sd65536;
      default: begin
        case ($urandom_range(0, 3))
          0: return $urandom;
          1: return $signed($urandom_range(0, 262143)) - 131072;
          2: begin
            case ($urandom_range(0, 4))
              0: return 32'h7fffffff;
              1: return 32'h80000000;
              2: return 0;
              3: return 32'sd65536;
              default: return -32'sd65536;
            endcase
          end
          default: return 32'sd65536 + $signed($urandom_range(0, 8191)) - 4096;
        endcase
      end
    endcase
  endfunction

  function in_item_t make_row(input int bone, input int parent, input int row,
                              input bit last, input int mode);
    in_item_t it;
    it.bone_index   = bone[7:0];
    it.parent_index = parent[7:0];
    it.row_index    = row[1:0];
    it.local_c0     = rand_word(mode);
    it.local_c1     = rand_word(mode);
    it.local_c2     = rand_word(mode);
    it.local_c3     = rand_word(mode);
    it.offset_c0    = rand_word(mode);
    it.offset_c1    = rand_word(mode);
    it.offset_c2    = rand_word(mode);
    it.offset_c3    = rand_word(mode);
    it.last_bone    = last;
    return it;
  endfunction

  task send_row(input in_item_t it);
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(0, 99) < (idle_mode == 1 ? 81 : 7)) begin
        in_valid_i <= 0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note(it);
  endtask

  task send_bone(input int bone, input int parent, input bit last, input int mode);
    for (int r = 0; r < 4; r++) send_row(make_row(bone, parent, r, last, mode));
  endtask

  initial begin
    int n_rand;
    int bone;
    int parent;
    int tries;
    in_item_t it;
    sb = new();
    idle_mode   = 0;
    rst_ni      = 0;
    in_valid_i  = 0;
    in_data_i   = '0;
    out_stall_i = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes, chained parents, a bone that is its own parent,
    // reordered rows, and the last-bone mark on an early row.
    send_bone(0, 8'hff, 0, 1);
    send_bone(0, 0, 0, 2);
    send_bone(0, 0, 0, 3);
    send_bone(1, 0, 0, 3);
    send_bone(2, 1, 0, 0);
    send_row(make_row(2, 2, 3, 1, 0));
    send_row(make_row(2, 2, 0, 1, 0));
    send_row(make_row(2, 2, 1, 0, 0));
    send_bone(255, 2, 1, 1);
    send_bone(170, 255, 1, 2);

    n_rand = 0;
    while (n_rand < 100) begin
      idle_mode = (n_rand / 25) % 4;
      if ($urandom_range(0, 99) < 80) begin
        bone = ($urandom_range(0, 99) < 25) ? 0 : $urandom_range(1, 255);
        parent = $urandom_range(0, 255);
        if (bone != 0) begin
          tries = 0;
          while (!sb.bone_complete(parent) && tries < 64) begin
            parent = $urandom_range(0, 255);
            tries++;
          end
          if (!sb.bone_complete(parent)) parent = 0;
          if ($urandom_range(0, 9) == 0 && sb.bone_complete(bone)) parent = bone;
        end
        send_bone(bone, parent, $urandom_range(0, 1), 0);
        n_rand += 4;
      end else begin
        tries = 0;
        do begin
          it = make_row($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 3), $urandom_range(0, 1), 0);
          tries++;
        end while (!sb.legal(it) && tries < 200);
        if (sb.legal(it)) begin
          send_row(it);
          n_rand++;
        end
      end
    end
    in_valid_i <= 0;
    idle_mode = 0;

    while (sb.pending_rows.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rows.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
